// ===== hw/rtl/qmn_pkg.sv =====
// Shared types for the normalised quaternion product pipeline.
package qmn_pkg;

  // Pipeline control handed to each divider lane.
  typedef struct packed {
    logic advance;
    logic valid;
  } pipe_ctl_t;

endpackage

// ===== hw/rtl/qmn_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, rounded to nearest.
module qmn_div #(
  parameter int W  = 32,
  parameter int F  = 30,
  parameter int LW = 33
) (
  input  logic               clk,
  input  logic               rst,
  input  qmn_pkg::pipe_ctl_t ctl,
  input  logic [W-1:0]       mag,
  input  logic               neg,
  input  logic [LW-1:0]      len,
  output logic               valid_out,
  output logic               neg_out,
  output logic [F:0]         quot
);

  localparam int DW = LW + 1;
  localparam int NW = W + F + 1;
  localparam int NS = F + 1;

  logic [NW-1:0] num [0:NS];
  logic [DW-1:0] dvs [0:NS];
  logic [DW-1:0] rem [0:NS];
  logic [F:0]    qt  [0:NS];
  logic          ng  [0:NS];
  logic          vld [0:NS];

  // Numerator is 2*|c|*2^F + L; the divisor is 2*L.
  assign num[0] = {mag, {(F + 1){1'b0}}} + NW'(len);
  assign dvs[0] = {len, 1'b0};
  assign rem[0] = DW'(num[0][NW-1:F+1]);
  assign qt[0]  = '0;
  assign ng[0]  = neg;
  assign vld[0] = ctl.valid;

  for (genvar j = 0; j < NS; j++) begin : g_step
    localparam int I = F - j;
    logic [DW:0] shifted;
    logic        take;

    // Bring down the next numerator bit and try the subtraction.
    assign shifted = {rem[j], num[j][I]};
    assign take    = shifted >= {1'b0, dvs[j]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (ctl.advance) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.advance) begin
        num[j+1] <= num[j];
        dvs[j+1] <= dvs[j];
        ng[j+1]  <= ng[j];
        rem[j+1] <= take ? DW'(shifted - {1'b0, dvs[j]}) : shifted[DW-1:0];
        qt[j+1]  <= take ? (qt[j] | ((F + 1)'(1) << I)) : qt[j];
      end
    end
  end

  assign valid_out = vld[NS];
  assign neg_out   = ng[NS];
  assign quot      = qt[NS];

endmodule

// ===== hw/rtl/quaternion_multiply_normalize_top.sv =====
// Top level: Hamilton product of two quaternions, rounded, clipped and normalised.
//
//  Channel  Handshake             Payload
//  input    in_valid / in_ready   first_x..first_w, second_x..second_w
//  output   out_valid / out_ready prod_x..prod_w, zero_length, saturated
//
// One transaction is accepted per cycle when the output side keeps up.
// The pipeline holds five arithmetic stages, one square-root stage per root bit,
// one divider stage per quotient bit and the output register.
// Reset clears only the valid bits; the data path registers are not reset.
// A stall at the output freezes every stage together, so nothing is lost or repeated.
module quaternion_multiply_normalize_top #(
  parameter int COMPONENT_WIDTH = 32,
  parameter int FRACTION_BITS   = 30
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [COMPONENT_WIDTH-1:0] first_x,
  input  logic signed [COMPONENT_WIDTH-1:0] first_y,
  input  logic signed [COMPONENT_WIDTH-1:0] first_z,
  input  logic signed [COMPONENT_WIDTH-1:0] first_w,
  input  logic signed [COMPONENT_WIDTH-1:0] second_x,
  input  logic signed [COMPONENT_WIDTH-1:0] second_y,
  input  logic signed [COMPONENT_WIDTH-1:0] second_z,
  input  logic signed [COMPONENT_WIDTH-1:0] second_w,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [COMPONENT_WIDTH-1:0] prod_x,
  output logic signed [COMPONENT_WIDTH-1:0] prod_y,
  output logic signed [COMPONENT_WIDTH-1:0] prod_z,
  output logic signed [COMPONENT_WIDTH-1:0] prod_w,
  output logic                              zero_length,
  output logic                              saturated
);

  localparam int W  = COMPONENT_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int PW = 2 * W;
  localparam int SW = 2 * W + 2;
  localparam int LW = W + 1;
  localparam int NS = F + 1;
  localparam int MW = ((F + 1) > W ? (F + 1) : W) + 1;

  localparam logic [SW-1:0] HALF    = SW'(1) << (F - 1);
  localparam logic [SW-1:0] LIM_NEG = SW'(1) << (W - 1);
  localparam logic [SW-1:0] LIM_POS = LIM_NEG - SW'(1);
  localparam logic [MW-1:0] OUT_POS = (MW'(1) << (W - 1)) - MW'(1);
  localparam logic [MW-1:0] OUT_NEG = MW'(1) << (W - 1);

  logic advance;
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  // Component order throughout: x, y, z, w.
  logic signed [W-1:0] qa [4];
  logic signed [W-1:0] qb [4];
  assign qa = '{first_x, first_y, first_z, first_w};
  assign qb = '{second_x, second_y, second_z, second_w};

  // Stage 1: all sixteen cross products.
  logic signed [PW-1:0] p1 [16];
  logic                 v1;
  for (genvar i = 0; i < 4; i++) begin : g_mul_i
    for (genvar j = 0; j < 4; j++) begin : g_mul_j
      always_ff @(posedge clk) begin
        if (advance) begin
          p1[i*4+j] <= PW'(qa[i]) * PW'(qb[j]);
        end
      end
    end
  end

  // Stage 2: Hamilton sums, exact with 2F fraction bits.
  logic signed [SW-1:0] s2 [4];
  logic                 v2;
  always_ff @(posedge clk) begin
    if (advance) begin
      s2[0] <= SW'(p1[12]) + SW'(p1[3]) + SW'(p1[6]) - SW'(p1[9]);
      s2[1] <= SW'(p1[13]) - SW'(p1[2]) + SW'(p1[7]) + SW'(p1[8]);
      s2[2] <= SW'(p1[14]) + SW'(p1[1]) - SW'(p1[4]) + SW'(p1[11]);
      s2[3] <= SW'(p1[15]) - SW'(p1[0]) - SW'(p1[5]) - SW'(p1[10]);
    end
  end

  // Stage 3: round the magnitude half up, then clip to the component range.
  logic [3:0]         neg3;
  logic [3:0][W-1:0]  mag3;
  logic [3:0]         clip3;
  logic               v3;
  for (genvar k = 0; k < 4; k++) begin : g_round
    logic          sgn;
    logic [SW-1:0] amag;
    logic [SW-1:0] rnd;
    logic [SW-1:0] lim;
    assign sgn  = s2[k][SW-1];
    assign amag = sgn ? SW'(-s2[k]) : SW'(s2[k]);
    assign rnd  = (amag + HALF) >> F;
    assign lim  = sgn ? LIM_NEG : LIM_POS;
    always_ff @(posedge clk) begin
      if (advance) begin
        neg3[k]  <= sgn;
        clip3[k] <= rnd > lim;
        mag3[k]  <= (rnd > lim) ? lim[W-1:0] : rnd[W-1:0];
      end
    end
  end

  // Stage 4: squares of the clipped magnitudes.
  logic [3:0][PW-1:0] sq4;
  logic [3:0]         neg4;
  logic [3:0][W-1:0]  mag4;
  logic               sat4;
  logic               v4;
  for (genvar k = 0; k < 4; k++) begin : g_square
    always_ff @(posedge clk) begin
      if (advance) begin
        sq4[k] <= PW'(mag3[k]) * PW'(mag3[k]);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (advance) begin
      neg4 <= neg3;
      mag4 <= mag3;
      sat4 <= |clip3;
    end
  end

  // Square-root pipeline, one root bit per stage; entry 0 is the stage 5 register.
  logic [SW-1:0]      sq_rem  [0:LW];
  logic [LW-1:0]      sq_root [0:LW];
  logic [3:0]         sq_neg  [0:LW];
  logic [3:0][W-1:0]  sq_mag  [0:LW];
  logic               sq_zero [0:LW];
  logic               sq_sat  [0:LW];
  logic               sq_vld  [0:LW];
  logic [SW-1:0]      sum_sq;

  // Stage 5: sum of squares.
  assign sum_sq = SW'(sq4[0]) + SW'(sq4[1]) + SW'(sq4[2]) + SW'(sq4[3]);
  always_ff @(posedge clk) begin
    if (advance) begin
      sq_rem[0]  <= sum_sq;
      sq_root[0] <= '0;
      sq_neg[0]  <= neg4;
      sq_mag[0]  <= mag4;
      sq_zero[0] <= sum_sq == '0;
      sq_sat[0]  <= sat4;
    end
  end

  // Valid bits of the front stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      sq_vld[0] <= 1'b0;
    end else if (advance) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      sq_vld[0] <= v4;
    end
  end

  for (genvar j = 0; j < LW; j++) begin : g_sqrt
    localparam int K = LW - 1 - j;
    logic [SW:0] trial;
    logic        take;

    // Try setting root bit K: subtract (2*root + 2^K) * 2^K from the remainder.
    assign trial = ((SW + 1)'(sq_root[j]) << (K + 1)) + ((SW + 1)'(1) << (2 * K));
    assign take  = trial <= (SW + 1)'(sq_rem[j]);

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[j+1] <= 1'b0;
      end else if (advance) begin
        sq_vld[j+1] <= sq_vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        sq_rem[j+1]  <= take ? (sq_rem[j] - trial[SW-1:0]) : sq_rem[j];
        sq_root[j+1] <= take ? (sq_root[j] | (LW'(1) << K)) : sq_root[j];
        sq_neg[j+1]  <= sq_neg[j];
        sq_mag[j+1]  <= sq_mag[j];
        sq_zero[j+1] <= sq_zero[j];
        sq_sat[j+1]  <= sq_sat[j];
      end
    end
  end

  // Four divider lanes share the length.
  qmn_pkg::pipe_ctl_t div_ctl;
  logic [3:0]         dv_vld;
  logic [3:0]         dv_neg;
  logic [F:0]         dv_q [4];

  assign div_ctl.advance = advance;
  assign div_ctl.valid   = sq_vld[LW];

  for (genvar k = 0; k < 4; k++) begin : g_div
    qmn_div #(
      .W  (W),
      .F  (F),
      .LW (LW)
    ) u_div (
      .clk       (clk),
      .rst       (rst),
      .ctl       (div_ctl),
      .mag       (sq_mag[LW][k]),
      .neg       (sq_neg[LW][k]),
      .len       (sq_root[LW]),
      .valid_out (dv_vld[k]),
      .neg_out   (dv_neg[k]),
      .quot      (dv_q[k])
    );
  end

  // Flags travel beside the divider lanes.
  logic dz [0:NS];
  logic ds [0:NS];
  assign dz[0] = sq_zero[LW];
  assign ds[0] = sq_sat[LW];
  for (genvar j = 0; j < NS; j++) begin : g_flag
    always_ff @(posedge clk) begin
      if (advance) begin
        dz[j+1] <= dz[j];
        ds[j+1] <= ds[j];
      end
    end
  end

  // Output stage: clip the quotient, restore the sign, force zero for zero length.
  logic [W-1:0] res [4];
  for (genvar k = 0; k < 4; k++) begin : g_out
    logic [MW-1:0] qe;
    logic [MW-1:0] lim;
    logic [MW-1:0] m;
    logic [MW-1:0] sv;
    assign qe  = MW'(dv_q[k]);
    assign lim = dv_neg[k] ? OUT_NEG : OUT_POS;
    assign m   = (qe > lim) ? lim : qe;
    assign sv  = dv_neg[k] ? (~m + MW'(1)) : m;
    assign res[k] = dz[NS] ? '0 : sv[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= &dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prod_x      <= res[0];
      prod_y      <= res[1];
      prod_z      <= res[2];
      prod_w      <= res[3];
      zero_length <= dz[NS];
      saturated   <= ds[NS];
    end
  end

  // The divider lanes must stay in step with one another.
  assert property (@(posedge clk) disable iff (rst)
                   dv_vld == 4'b0000 || dv_vld == 4'b1111)
    else $error("divider lanes out of step");

  // A zero-length result carries all-zero components.
  assert property (@(posedge clk) disable iff (rst) out_valid && zero_length |->
                   prod_x == '0 && prod_y == '0 && prod_z == '0 && prod_w == '0)
    else $error("zero-length result with non-zero component");

  // A non-zero length always yields at least one non-zero component.
  assert property (@(posedge clk) disable iff (rst) out_valid && !zero_length |->
                   prod_x != '0 || prod_y != '0 || prod_z != '0 || prod_w != '0)
    else $error("normalised result collapsed to zero");

  // A stalled output holds the whole pipeline, front stage included.
  assert property (@(posedge clk) disable iff (rst) out_valid && !out_ready |=>
                   $stable(v1) && $stable(sq_vld[0]))
    else $error("pipeline moved during a stall");

endmodule
